@@ sv/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and codes for the top-k score collector.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int SCORE_W       = 32;
    localparam int ROW_W         = 48;
    localparam int LIMIT_W       = 7;
    localparam int OP_W          = 2;
    localparam int KIND_W        = 2;
    localparam int MAX_KEEP_DEF  = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_OFFER  = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_THRESH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    // one heap entry
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [ROW_W-1:0]   row_id;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/tsc_in_if.sv @@
// ----------------------------------------------------------------------------
// tsc_in_if
// Candidate channel: operation, row id and score with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if
    import tsc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [ROW_W-1:0]          row_id;
    logic signed [SCORE_W-1:0] score;

    modport source (output valid, operation, row_id, score, input ready);
    modport sink   (input valid, operation, row_id, score, output ready);
endinterface

`default_nettype wire

@@ sv/tsc_out_if.sv @@
// ----------------------------------------------------------------------------
// tsc_out_if
// Result channel: kind, row id, score and last flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_out_if
    import tsc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [ROW_W-1:0]          out_row_id;
    logic signed [SCORE_W-1:0] out_score;
    logic                      last;

    modport source (output valid, kind, out_row_id, out_score, last, input ready);
    modport sink   (input valid, kind, out_row_id, out_score, last, output ready);
endinterface

`default_nettype wire

@@ sv/topk_score_collector.sv @@
// ----------------------------------------------------------------------------
// topk_score_collector
// Keeps the best keep_limit (row id, score) pairs in a binary min-heap.
// ----------------------------------------------------------------------------
// The heap lives in one memory of MAX_KEEP entries (one write port, one read
// port, registered read data). One transaction is worked on at a time; the
// input is ready only while the sequencer is idle. An insert sifts up with one
// parent read per level; a replacement does a root check, a sift down reading
// up to two children per level, a sift up and a root read for the threshold;
// a finish emits the root and pops it for each drained entry. A result waits
// in the output register until taken; the sequencer stalls only when it has a
// new result and that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module topk_score_collector
    import tsc_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_wdata,
    tsc_in_if.sink                  i_cand,
    tsc_out_if.source               o_res
);

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int PW = CW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP     = 4'd1;
    localparam logic [3:0] S_UP2    = 4'd2;
    localparam logic [3:0] S_POP    = 4'd3;
    localparam logic [3:0] S_POP2   = 4'd4;
    localparam logic [3:0] S_DOWN   = 4'd5;
    localparam logic [3:0] S_DL     = 4'd6;
    localparam logic [3:0] S_DR     = 4'd7;
    localparam logic [3:0] S_DRROOT = 4'd8;
    localparam logic [3:0] S_DREMIT = 4'd9;
    localparam logic [3:0] S_TH     = 4'd10;
    localparam logic [3:0] S_TH2    = 4'd11;
    localparam logic [3:0] S_RROOT  = 4'd12;
    localparam logic [3:0] S_RCMP   = 4'd13;
    localparam logic [3:0] S_EMPTY  = 4'd14;

    t_entry r_mem [MAX_KEEP];
    t_entry r_rd;

    logic [3:0]         r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [PW-1:0]      r_pos, n_pos;
    t_entry             r_cur, n_cur;
    t_entry             r_new, n_new;
    t_entry             r_child, n_child;
    logic               r_repl, n_repl;

    logic               r_ovalid, n_ovalid;
    logic [KIND_W-1:0]  r_okind, n_okind;
    t_entry             r_odata, n_odata;
    logic               r_olast, n_olast;

    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    t_entry             wdata;

    logic [LW-1:0]      lim;
    logic [PW-1:0]      lpos, rpos, ppos, cnt_p;
    logic               out_free;
    t_entry             best;
    logic [PW-1:0]      best_pos;

    // effective limit saturates at capacity
    assign lim = (LW'(r_limit) > LW'(MAX_KEEP)) ? LW'(MAX_KEEP) : LW'(r_limit);

    assign cnt_p    = PW'(r_cnt);
    assign lpos     = {r_pos[PW-2:0], 1'b1};
    assign rpos     = lpos + PW'(1);
    assign ppos     = (r_pos - PW'(1)) >> 1;
    assign out_free = !r_ovalid || o_res.ready;

    // smaller child: right only when strictly smaller than left
    always_comb begin
        best     = r_rd;
        best_pos = lpos;
        if (r_state == S_DR) begin
            if (r_rd.score < r_child.score) begin
                best     = r_rd;
                best_pos = rpos;
            end else begin
                best     = r_child;
                best_pos = lpos;
            end
        end
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= r_mem[raddr];
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_cur    = r_cur;
        n_new    = r_new;
        n_child  = r_child;
        n_repl   = r_repl;
        n_ovalid = r_ovalid && !o_res.ready;
        n_okind  = r_okind;
        n_odata  = r_odata;
        n_olast  = r_olast;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = r_pos[AW-1:0];
        raddr    = '0;
        wdata    = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_cand.valid) begin
                    n_new = '{score: i_cand.score, row_id: i_cand.row_id};
                    unique case (i_cand.operation)
                        OP_OFFER: begin
                            if (lim != '0) begin
                                if (LW'(r_cnt) < lim) begin
                                    n_cur   = '{score: i_cand.score, row_id: i_cand.row_id};
                                    n_pos   = cnt_p;
                                    n_cnt   = r_cnt + CW'(1);
                                    n_repl  = 1'b0;
                                    n_state = S_UP;
                                end else if (r_cnt != '0) begin
                                    n_state = S_RROOT;
                                end
                            end
                        end
                        OP_FINISH: begin
                            n_repl  = 1'b0;
                            n_state = (r_cnt == '0) ? S_EMPTY : S_DRROOT;
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // sift up: compare with parent
            S_UP: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = r_repl ? S_TH : S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = ppos[AW-1:0];
                    n_state = S_UP2;
                end
            end

            S_UP2: begin
                we = 1'b1;
                if (r_cur.score < r_rd.score) begin
                    wdata   = r_rd;
                    n_pos   = ppos;
                    n_state = S_UP;
                end else begin
                    n_state = r_repl ? S_TH : S_IDLE;
                end
            end

            // pop: move last entry to the root
            S_POP: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_POP2;
                end else begin
                    re      = 1'b1;
                    raddr   = AW'(r_cnt - CW'(1));
                    n_state = S_POP2;
                end
            end

            S_POP2: begin
                if (r_cnt == '0) begin
                    // heap now empty: pop done
                    if (r_repl) begin
                        n_cur   = r_new;
                        n_pos   = cnt_p;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_UP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cur   = r_rd;
                    n_pos   = '0;
                    n_state = S_DOWN;
                end
            end

            // sift down: read left child
            S_DOWN: begin
                if (lpos >= cnt_p) begin
                    we = 1'b1;
                    if (r_repl) begin
                        n_cur   = r_new;
                        n_pos   = cnt_p;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_UP;
                    end else begin
                        n_state = (r_cnt == '0) ? S_IDLE : S_DRROOT;
                    end
                end else begin
                    re      = 1'b1;
                    raddr   = lpos[AW-1:0];
                    n_state = S_DL;
                end
            end

            S_DL, S_DR: begin
                if (r_state == S_DL && rpos < cnt_p) begin
                    n_child = r_rd;
                    re      = 1'b1;
                    raddr   = rpos[AW-1:0];
                    n_state = S_DR;
                end else begin
                    we = 1'b1;
                    if (best.score < r_cur.score) begin
                        wdata   = best;
                        n_pos   = best_pos;
                        n_state = S_DOWN;
                    end else if (r_repl) begin
                        n_cur   = r_new;
                        n_pos   = cnt_p;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_UP;
                    end else begin
                        n_state = (r_cnt == '0) ? S_IDLE : S_DRROOT;
                    end
                end
            end

            // drain: emit root then pop
            S_DRROOT: begin
                re      = 1'b1;
                n_state = S_DREMIT;
            end

            S_DREMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_ROW;
                    n_odata  = r_rd;
                    n_olast  = (r_cnt == CW'(1));
                    n_state  = S_POP;
                end
            end

            // threshold after replacement
            S_TH: begin
                re      = 1'b1;
                n_state = S_TH2;
            end

            S_TH2: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_THRESH;
                    n_odata  = '{score: r_rd.score, row_id: '0};
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // full heap: compare offer with minimum
            S_RROOT: begin
                re      = 1'b1;
                n_state = S_RCMP;
            end

            S_RCMP: begin
                if (r_rd.score < r_new.score) begin
                    n_repl  = 1'b1;
                    n_state = S_POP;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_EMPTY: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_EMPTY;
                    n_odata  = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_limit  <= '0;
            r_ovalid <= 1'b0;
            r_repl   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_repl   <= n_repl;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_cur   <= n_cur;
        r_new   <= n_new;
        r_child <= n_child;
        r_okind <= n_okind;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign i_cand.ready     = (r_state == S_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.kind       = r_okind;
    assign o_res.out_row_id = r_odata.row_id;
    assign o_res.out_score  = r_odata.score;
    assign o_res.last       = r_olast;

endmodule

`default_nettype wire

@@ sim/tb_topk_score_collector.sv @@
// ----------------------------------------------------------------------------
// tb_topk_score_collector
// Self-checking bench for the top-k score collector: drives offer, finish,
// clear and unused-op transactions, predicts results with a behavioral
// min-heap and checks every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_topk_score_collector;
    import tsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEEP = MAX_KEEP_DEF;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ROW_W-1:0]          row_id;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    tsc_in_if  cand_if ();
    tsc_out_if res_if ();

    topk_score_collector #(.MAX_KEEP(MAX_KEEP)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cand      (cand_if.sink),
        .o_res       (res_if.source)
    );

    // predictor state
    logic signed [SCORE_W-1:0] mdl_score [MAX_KEEP];
    logic [ROW_W-1:0]          mdl_row   [MAX_KEEP];
    int                        mdl_held;
    int                        mdl_limit;

    t_result expected_q[$];
    int      mismatch_cnt;
    int      fail_cnt;
    bit      long_hold;
    int      burst_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #50ms;
        $display("FAIL topk_score_collector");
        $finish;
    end

    // heap helpers
    function automatic void heap_swap(int a, int b);
        logic signed [SCORE_W-1:0] s;
        logic [ROW_W-1:0]          r;
        s = mdl_score[a]; r = mdl_row[a];
        mdl_score[a] = mdl_score[b]; mdl_row[a] = mdl_row[b];
        mdl_score[b] = s; mdl_row[b] = r;
    endfunction

    function automatic void heap_push(logic signed [SCORE_W-1:0] s, logic [ROW_W-1:0] r);
        int i;
        int p;
        if (mdl_held >= MAX_KEEP) return;
        i = mdl_held;
        mdl_held++;
        mdl_score[i] = s;
        mdl_row[i]   = r;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(mdl_score[i] < mdl_score[p])) break;
            heap_swap(i, p);
            i = p;
        end
    endfunction

    function automatic void heap_pop();
        int i;
        int l;
        int c;
        i = 0;
        if (mdl_held == 0) return;
        mdl_held--;
        if (mdl_held == 0) return;
        mdl_score[0] = mdl_score[mdl_held];
        mdl_row[0]   = mdl_row[mdl_held];
        forever begin
            l = 2 * i + 1;
            if (l >= mdl_held) break;
            c = l;
            if (l + 1 < mdl_held && mdl_score[l+1] < mdl_score[l]) c = l + 1;
            if (!(mdl_score[c] < mdl_score[i])) break;
            heap_swap(i, c);
            i = c;
        end
    endfunction

    // append one expected result at the tail of the queue
    function automatic void add_expected(t_result r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // predict the results of one accepted transaction
    function automatic void predict_topk(logic [OP_W-1:0] op, logic [ROW_W-1:0] rid,
                                         logic signed [SCORE_W-1:0] sc);
        int      lim;
        t_result r;
        lim = (mdl_limit > MAX_KEEP) ? MAX_KEEP : mdl_limit;
        case (op)
            OP_OFFER: begin
                if (lim == 0) return;
                if (mdl_held < lim) begin
                    heap_push(sc, rid);
                end else if (mdl_held > 0 && mdl_score[0] < sc) begin
                    heap_pop();
                    heap_push(sc, rid);
                    r = '{KIND_THRESH, '0, mdl_score[0], 1'b1};
                    add_expected(r);
                end
            end
            OP_FINISH: begin
                if (mdl_held == 0) begin
                    r = '{KIND_EMPTY, '0, '0, 1'b1};
                    add_expected(r);
                end
                while (mdl_held > 0) begin
                    r.kind   = KIND_ROW;
                    r.row_id = mdl_row[0];
                    r.score  = mdl_score[0];
                    heap_pop();
                    r.last   = (mdl_held == 0);
                    add_expected(r);
                end
            end
            OP_CLEAR: mdl_held = 0;
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.kind, res_if.out_row_id, res_if.out_score, res_if.last};
            if (expected_q.size() == 0) begin
                fail_cnt++;
                if (mismatch_cnt < 10)
                    $display("unexpected result transaction %p", got);
                mismatch_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    fail_cnt++;
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver stall pattern, with an optional long hold-off
    initial begin
        int pat;
        int hold;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                res_if.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge i_clk);
                long_hold = 0;
            end
            pat = $urandom_range(0, 15);
            res_if.ready <= (pat < 4) ? 1'b0 : 1'b1;
        end
    end

    // send one transaction; bursts with random gaps in between
    task automatic send_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] rid,
                             logic signed [SCORE_W-1:0] sc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cand_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cand_if.valid     <= 1'b1;
        cand_if.operation <= op;
        cand_if.row_id    <= rid;
        cand_if.score     <= sc;
        do @(posedge i_clk); while (!cand_if.ready);
        predict_topk(op, rid, sc);
    endtask

    task automatic drain_idle();
        cand_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
    endtask

    task automatic write_limit(int value);
        drain_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[LIMIT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_limit = value;
    endtask

    function automatic logic [ROW_W-1:0] rand_row();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ROW_W-1:0];
    endfunction

    // random score, often clustered to create ties
    function automatic logic signed [SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return -$signed($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // edge values, limit zero, empty finish, unused op, clear
    task automatic test_directed();
        write_limit(0);
        send_item(OP_OFFER, '1, 32'sh7fffffff);
        send_item(OP_FINISH, '0, '0);
        write_limit(3);
        send_item(OP_OFFER, '1, 32'sh80000000);
        send_item(OP_OFFER, '0, 32'sh7fffffff);
        send_item(OP_OFFER, 48'h5, 32'sd0);
        send_item(OP_OFFER, 48'h6, 32'sh80000000);
        send_item(OP_OFFER, 48'h7, 32'sd1);
        send_item(OP_OFFER, 48'h8, 32'sd1);
        send_item(2'd3, '1, '1);
        send_item(OP_FINISH, '0, '0);
        send_item(OP_OFFER, 48'h9, 32'sd5);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_FINISH, '1, '1);
        // lower the limit while full
        write_limit(4);
        for (int k = 0; k < 4; k++) send_item(OP_OFFER, rand_row(), k);
        write_limit(2);
        send_item(OP_OFFER, 48'hA, 32'sd10);
        send_item(OP_OFFER, 48'hB, -32'sd1);
        send_item(OP_FINISH, '0, '0);
    endtask

    // random phases across several limits, including above capacity
    task automatic test_random();
        int limits[6] = '{1, 5, 64, 127, 17, 2};
        int n;
        int pick;
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            n = (limits[ph] >= 64) ? 80 : 15;
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 31);
                if (pick == 0)      send_item(OP_CLEAR, rand_row(), rand_score());
                else if (pick == 1) send_item(2'd3, rand_row(), rand_score());
                else if (pick < 4)  send_item(OP_FINISH, rand_row(), rand_score());
                else                send_item(OP_OFFER, rand_row(), rand_score());
            end
            send_item(OP_FINISH, '0, '0);
        end
    endtask

    // long receiver hold-off while offers keep coming
    task automatic test_backpressure();
        write_limit(3);
        long_hold = 1;
        for (int k = 0; k < 20; k++) send_item(OP_OFFER, rand_row(), 100 + k);
        send_item(OP_FINISH, '0, '0);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        cand_if.valid     <= 1'b0;
        cand_if.operation <= OP_OFFER;
        cand_if.row_id    <= '0;
        cand_if.score     <= '0;
        mdl_held = 0;
        mdl_limit = 0;
        mismatch_cnt = 0;
        fail_cnt = 0;
        long_hold = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        drain_idle();

        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("PASS topk_score_collector");
        end else begin
            $display("FAIL topk_score_collector");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/tsc_pkg.sv
sv/tsc_in_if.sv
sv/tsc_out_if.sv
sv/topk_score_collector.sv
sim/tb_topk_score_collector.sv
